[hdl/tmf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_pkg
// Shared constants for the trimmed mean filter.
// ----------------------------------------------------------------------------
package tmf_pkg;

  localparam int DEF_MAX_SAMPLES = 128;
  localparam int SAMPLE_W        = 16;
  localparam int MEAN_W          = 24;
  localparam int FRAC_BITS       = 8;
  localparam int SCOUNT_W        = 8;
  localparam int TCOUNT_W        = 7;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 8;

  localparam logic [SCOUNT_W-1:0] SCOUNT_RESET = 8'd100;
  localparam logic [TCOUNT_W-1:0] TCOUNT_RESET = 7'd11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_COUNT   = 1'b1;

endpackage

[hdl/trimmed_mean_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_mean_filter
// Trimmed mean of a burst of unsigned 16-bit samples, Q16.8 result.
// ----------------------------------------------------------------------------
// Usage:
//   Samples arrive on in_valid/in_stall/sample, one request per cycle while
//   a burst is collected; each sample is written to an on-chip sample memory.
//   When sample_count samples have arrived (saturated into 1..MAX_SAMPLES)
//   the block stalls its input and ranks each of the n stored samples
//   against all others through the single memory read port. Samples ranked
//   inside the kept window are summed, then a bit-serial divider forms the
//   mean. If 2*trim_count >= n the ranking and divide are skipped and
//   trim_error is returned with a zero mean. Bursts of other lengths give
//   no result.
//   The result sits in an output register; the input keeps taking samples of
//   the next burst while it waits on out_stall. A finished burst result waits
//   in the block until the output register is free.
//   Configuration writes (cfg_valid/cfg_ready, index 0 = sample_count,
//   1 = trim_count) are always taken; they are meant for idle periods.
//   Synchronous reset clears the burst count, the handshake state and the
//   registers to 100 and 11. The sample memory is not cleared.
// ----------------------------------------------------------------------------
module trimmed_mean_filter
  import tmf_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MEAN_W-1:0]     mean_value,
  output logic                  trim_error,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW   = $clog2(MAX_SAMPLES);
  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int EW   = (CW > SCOUNT_W) ? CW + 1 : SCOUNT_W + 1;
  localparam int SUMW = SAMPLE_W + CW;
  localparam int DW   = SUMW + FRAC_BITS;
  localparam int DCW  = $clog2(DW);

  typedef enum logic [2:0] {
    S_COLLECT, S_OUT_REQ, S_OUT_CAP, S_SWEEP, S_DIVIDE, S_EMIT
  } state_t;

  state_t               state;
  logic [SCOUNT_W-1:0]  sample_count;
  logic [TCOUNT_W-1:0]  trim_count;
  logic [SAMPLE_W-1:0]  mem [MAX_SAMPLES];
  logic [SAMPLE_W-1:0]  rd_data;
  logic [AW-1:0]        rd_addr;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        n_len;
  logic [CW-1:0]        lo_rank;
  logic [CW-1:0]        hi_rank;
  logic [CW-1:0]        keep;
  logic [CW-1:0]        idx_i;
  logic [CW-1:0]        idx_j;
  logic [CW-1:0]        idx_d;
  logic [CW-1:0]        rank;
  logic [SAMPLE_W-1:0]  key;
  logic [SUMW-1:0]      sum;
  logic [DW-1:0]        dd;
  logic [CW:0]          rem;
  logic [DCW-1:0]       bit_cnt;
  logic                 err;

  logic                 accept;
  logic [CW-1:0]        cnt_inc;
  logic [EW-1:0]        sc_ext;
  logic [EW-1:0]        eff_len;
  logic                 burst_done;
  logic [EW-1:0]        t2_ext;
  logic                 trim_bad;
  logic                 hit;
  logic [CW-1:0]        rank_now;
  logic                 in_window;
  logic [CW+1:0]        rem_sh;
  logic                 q_bit;
  logic [CW:0]          rem_next;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_COLLECT) || rst;
  assign cfg_ready = 1'b1;

  // burst length saturated into 1..MAX_SAMPLES
  assign cnt_inc = cnt + CW'(1);
  assign sc_ext  = EW'(sample_count);
  always_comb begin
    eff_len = sc_ext;
    if (sc_ext == '0) begin
      eff_len = EW'(1);
    end else if (sc_ext > EW'(MAX_SAMPLES)) begin
      eff_len = EW'(MAX_SAMPLES);
    end
  end
  assign burst_done = EW'(cnt_inc) >= eff_len;
  assign t2_ext     = EW'({trim_count, 1'b0});
  assign trim_bad   = t2_ext >= EW'(cnt_inc);

  // rank compare, ties broken by position
  assign hit      = (rd_data < key) || ((rd_data == key) && (idx_d < idx_i));
  assign rank_now = rank + CW'(hit);
  assign in_window = (rank_now >= lo_rank) && (rank_now < hi_rank);

  // one restoring divide step
  assign rem_sh   = {rem, dd[DW-1]};
  assign q_bit    = rem_sh >= (CW+2)'(keep);
  assign rem_next = q_bit ? (CW+1)'(rem_sh - (CW+2)'(keep)) : rem_sh[CW:0];

  // memory read address
  always_comb begin
    case (state)
      S_OUT_REQ: rd_addr = idx_i[AW-1:0];
      S_OUT_CAP: rd_addr = '0;
      default:   rd_addr = idx_j[AW-1:0];
    endcase
  end

  // sample memory
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[cnt[AW-1:0]] <= sample;
    end
    rd_data <= mem[rd_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= SCOUNT_RESET;
      trim_count   <= TCOUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SAMPLE_COUNT: sample_count <= cfg_data;
        REG_TRIM_COUNT:   trim_count   <= cfg_data[TCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // burst control, ranking sweep, divider and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_COLLECT;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_COLLECT: begin
          if (accept) begin
            if (burst_done) begin
              cnt     <= '0;
              n_len   <= cnt_inc;
              lo_rank <= CW'(trim_count);
              hi_rank <= CW'(cnt_inc - CW'(trim_count));
              keep    <= CW'(EW'(cnt_inc) - t2_ext);
              err     <= trim_bad;
              sum     <= '0;
              idx_i   <= '0;
              state   <= trim_bad ? S_EMIT : S_OUT_REQ;
            end else begin
              cnt <= cnt_inc;
            end
          end
        end
        S_OUT_REQ: begin
          state <= S_OUT_CAP;
        end
        S_OUT_CAP: begin
          key   <= rd_data;
          rank  <= '0;
          idx_j <= CW'(1);
          idx_d <= '0;
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          rank  <= rank_now;
          idx_j <= idx_j + CW'(1);
          idx_d <= idx_j;
          if (idx_d == n_len - CW'(1)) begin
            if (in_window) begin
              sum <= sum + SUMW'(key);
            end
            idx_i <= idx_i + CW'(1);
            if (idx_i == n_len - CW'(1)) begin
              dd      <= {sum + (in_window ? SUMW'(key) : '0), FRAC_BITS'(0)};
              rem     <= '0;
              bit_cnt <= '0;
              state   <= S_DIVIDE;
            end else begin
              state <= S_OUT_REQ;
            end
          end
        end
        S_DIVIDE: begin
          rem     <= rem_next;
          dd      <= {dd[DW-2:0], q_bit};
          bit_cnt <= bit_cnt + DCW'(1);
          if (bit_cnt == DCW'(DW - 1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            trim_error <= err;
            mean_value <= err ? '0 : dd[MEAN_W-1:0];
            state      <= S_COLLECT;
          end
        end
        default: state <= S_COLLECT;
      endcase
    end
  end

endmodule

[hdl/tmf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_checker
// Port-level checks for the trimmed mean filter, bound to the top level.
// ----------------------------------------------------------------------------
module tmf_checker
  import tmf_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [MEAN_W-1:0] mean_value,
  input logic              trim_error
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mean_value) && $stable(trim_error))
    else $error("result changed while stalled");

  // error results carry a zero mean
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && trim_error |-> mean_value == '0)
    else $error("nonzero mean with trim error");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

  // a result appears only after the input was stalled for processing
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without processing");

endmodule

bind trimmed_mean_filter tmf_checker u_tmf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .mean_value (mean_value),
  .trim_error (trim_error)
);
